FILE: sv/hpg_pkg.sv
// ----------------------------------------------------------------------------
// hpg_pkg
// Shared types and constants of the core hotplug governor.
// ----------------------------------------------------------------------------
package hpg_pkg;

	localparam int NUM_CORES_DEF = 8;
	localparam int CNT_W         = 8;
	localparam int LVL_CALC_W    = 5;   // holds any level and NUM_CORES itself
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 8;
	localparam int IN_TDATA_W    = 32;
	localparam int OUT_TDATA_W   = 16;

	localparam logic [6:0]            IDLE_BUSY_PCT     = 7'd25;
	localparam logic [LVL_CALC_W-1:0] AWAKE_LEVEL_CAP   = 5'd6;
	localparam logic [LVL_CALC_W-1:0] SLEEP_LEVEL_FLOOR = 5'd6;
	localparam logic [LVL_CALC_W-1:0] RESUME_LEVEL      = 5'd0;
	localparam logic [LVL_CALC_W-1:0] UP_STEP           = 5'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UP_COUNT_LIMIT      = 3'd0,
		REG_DOWN_COUNT_LIMIT    = 3'd1,
		REG_UP_TASKS_PER_CORE   = 3'd2,
		REG_DOWN_TASKS_PER_CORE = 3'd3,
		REG_GPU_BOOST_LOAD      = 3'd4,
		REG_BUSY_UP_PCT         = 3'd5,
		REG_LOWEST_LEVEL_LOCK   = 3'd6,
		REG_HIGHEST_LEVEL_LOCK  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]        up_count_limit;
		logic [7:0]        down_count_limit;
		logic [3:0]        up_tasks_per_core;
		logic [3:0]        down_tasks_per_core;
		logic [6:0]        gpu_boost_load;
		logic [6:0]        busy_up_pct;
		logic signed [3:0] lowest_level_lock;
		logic signed [3:0] highest_level_lock;
	} cfg_t;

	typedef struct packed {
		logic       suspended;
		logic [6:0] gpu_load;
		logic [6:0] cpu_busy;
		logic [3:0] online_cores;
		logic [9:0] runnable_tasks;
	} item_t;

	typedef struct packed {
		logic       slow_sampling;
		logic       level_changed;
		logic [3:0] target_cores;
		logic [2:0] hotplug_level;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0] up_counter;
		logic [CNT_W-1:0] down_counter;
		logic             asleep_mode;
	} gov_state_t;

endpackage

FILE: sv/hpg_step.sv
// ----------------------------------------------------------------------------
// hpg_step
// Next-state and result logic for one sampling tick of the governor.
// ----------------------------------------------------------------------------
module hpg_step #(
	parameter int NUM_CORES = hpg_pkg::NUM_CORES_DEF,
	localparam int LW = $clog2(NUM_CORES)
) (
	input  hpg_pkg::cfg_t       cfg,
	input  hpg_pkg::item_t      item,
	input  hpg_pkg::gov_state_t st,
	input  logic [LW-1:0]       lvl,
	output hpg_pkg::gov_state_t st_nxt,
	output logic [LW-1:0]       lvl_nxt,
	output hpg_pkg::result_t    res
);
	import hpg_pkg::*;

	localparam logic [LVL_CALC_W-1:0] N_X     = LVL_CALC_W'(NUM_CORES);
	localparam logic [LVL_CALC_W-1:0] MAX_LVL = LVL_CALC_W'(NUM_CORES - 1);

	logic [7:0]            dn_prod, up_prod;
	logic                  boosted, few_tasks, count_up;
	logic [CNT_W-1:0]      up_c, dn_c;
	logic                  move_up, move_dn;
	logic [LVL_CALC_W-1:0] lvl_x, tgt, req, c1, c2, c3, c4, nxt_x, tgt_cores;
	logic                  req_en, req_force, entering, waking, changed;
	logic                  lo_on, hi_on;
	logic [LVL_CALC_W-1:0] lo_x, hi_x;

	always_comb begin
		dn_prod   = {4'b0, item.online_cores} * {4'b0, cfg.down_tasks_per_core};
		up_prod   = {4'b0, item.online_cores} * {4'b0, cfg.up_tasks_per_core};
		boosted   = item.gpu_load >= cfg.gpu_boost_load;
		few_tasks = ({2'b0, dn_prod} >= item.runnable_tasks) && !boosted;
		count_up  = (item.cpu_busy >= cfg.busy_up_pct
			&& {2'b0, up_prod} <= item.runnable_tasks) || boosted;

		up_c = st.up_counter;
		dn_c = st.down_counter;
		if (few_tasks) begin
			up_c = '0;
			if (item.cpu_busy <= IDLE_BUSY_PCT)
				dn_c = (dn_c == '1) ? dn_c : dn_c + 1'b1;
			else
				dn_c = '0;
		end else if (count_up) begin
			up_c = (up_c == '1) ? up_c : up_c + 1'b1;
			dn_c = '0;
		end

		move_up = up_c > cfg.up_count_limit;
		move_dn = !move_up && (dn_c > cfg.down_count_limit);

		// step the level: one core fewer, or up to four cores more
		lvl_x = LVL_CALC_W'(lvl);
		if (move_dn)
			tgt = (lvl_x >= MAX_LVL) ? MAX_LVL : lvl_x + 1'b1;
		else if (move_up)
			tgt = (lvl_x < UP_STEP) ? '0 : lvl_x - UP_STEP;
		else
			tgt = lvl_x;

		entering  = item.suspended && !st.asleep_mode;
		waking    = !item.suspended && st.asleep_mode;
		req_force = waking;
		if (entering) begin
			req_en = 1'b1;
			req    = SLEEP_LEVEL_FLOOR;
		end else if (waking) begin
			req_en = 1'b1;
			req    = RESUME_LEVEL;
		end else begin
			req_en = (N_X - lvl_x != {1'b0, item.online_cores}) || move_up || move_dn;
			req    = tgt;
		end

		// lock, screen and core-count clamps
		lo_on = !cfg.lowest_level_lock[3];
		hi_on = !cfg.highest_level_lock[3] && (cfg.highest_level_lock != '0);
		lo_x  = {2'b0, cfg.lowest_level_lock[2:0]};
		hi_x  = {2'b0, cfg.highest_level_lock[2:0]};
		c1 = (!req_force && lo_on && req > lo_x) ? lo_x : req;
		c2 = (!req_force && hi_on && c1 < hi_x) ? hi_x : c1;
		if (!item.suspended && c2 > AWAKE_LEVEL_CAP)
			c3 = AWAKE_LEVEL_CAP;
		else if (item.suspended && c2 < SLEEP_LEVEL_FLOOR)
			c3 = SLEEP_LEVEL_FLOOR;
		else
			c3 = c2;
		c4 = (c3 > MAX_LVL) ? MAX_LVL : c3;

		changed = req_en && (c4 != lvl_x);
		nxt_x   = changed ? c4 : lvl_x;
		lvl_nxt = nxt_x[LW-1:0];

		st_nxt.up_counter   = changed ? '0 : up_c;
		st_nxt.down_counter = changed ? '0 : dn_c;
		if (entering)
			st_nxt.asleep_mode = 1'b1;
		else if (waking)
			st_nxt.asleep_mode = 1'b0;
		else
			st_nxt.asleep_mode = st.asleep_mode;

		tgt_cores         = N_X - nxt_x;
		res.hotplug_level = nxt_x[2:0];
		res.target_cores  = tgt_cores[3:0];
		res.level_changed = changed;
		res.slow_sampling = st_nxt.asleep_mode;
	end

endmodule

FILE: sv/core_hotplug_governor_unit.sv
// ----------------------------------------------------------------------------
// core_hotplug_governor_unit
// Core hotplug governor with up/down hysteresis counters, suspend handling
// and level locks; one result transaction per sampling tick.
// ----------------------------------------------------------------------------
//
//  Channel   | Direction | Handshake                    | Payload
//  ----------+-----------+------------------------------+---------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | one tick sample (32 bit)
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | one tick result (16 bit)
//  cfg       | in        | cfg_we, no back-pressure     | register index, 8 bit data
//
//  From accept to result a sample passes the input register, where it is held,
//  then the result register; the whole step (counters, level clamp) runs between
//  them. One transaction per cycle sustained while m_axis_tready is held high.
//  Asynchronous active-low reset clears state, config registers to defaults.
//  A stalled result holds; a new sample is still taken while the input
//  register is empty or drains into the result register in the same cycle.
//
module core_hotplug_governor_unit #(
	parameter int NUM_CORES = hpg_pkg::NUM_CORES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// [9:0] runnable_tasks, [13:10] online_cores, [20:14] cpu_busy,
	// [27:21] gpu_load, [28] suspended, [31:29] zero
	input  logic [hpg_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [2:0] hotplug_level, [6:3] target_cores, [7] level_changed,
	// [8] slow_sampling, [15:9] zero
	output logic [hpg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic                            cfg_we,
	input  logic [hpg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hpg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import hpg_pkg::*;

	localparam int LW = $clog2(NUM_CORES);
	localparam logic [LVL_CALC_W-1:0] MAX_LVL = LVL_CALC_W'(NUM_CORES - 1);
	localparam logic [LVL_CALC_W-1:0] SLEEP_FLOOR =
		(SLEEP_LEVEL_FLOOR > MAX_LVL) ? MAX_LVL : SLEEP_LEVEL_FLOOR;

	cfg_t       cfg_q;
	item_t      item_s1;
	logic       vld_s1;
	result_t    res_s2;
	logic       vld_s2;
	gov_state_t st_q, st_nxt;
	logic [LW-1:0] lvl_q, lvl_nxt;
	result_t    res_nxt;
	logic       advance;
	logic [LVL_CALC_W-1:0] lvl_x;

	// move the held sample into the result register when that slot frees up
	assign advance       = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || advance;

	// configuration writes; every index of the port maps to a register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.up_count_limit      <= 8'd3;
			cfg_q.down_count_limit    <= 8'd3;
			cfg_q.up_tasks_per_core   <= 4'd2;
			cfg_q.down_tasks_per_core <= 4'd1;
			cfg_q.gpu_boost_load      <= 7'd80;
			cfg_q.busy_up_pct         <= 7'd60;
			cfg_q.lowest_level_lock   <= -4'sd1;
			cfg_q.highest_level_lock  <= -4'sd1;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_UP_COUNT_LIMIT:      cfg_q.up_count_limit      <= cfg_wdata;
				REG_DOWN_COUNT_LIMIT:    cfg_q.down_count_limit    <= cfg_wdata;
				REG_UP_TASKS_PER_CORE:   cfg_q.up_tasks_per_core   <= cfg_wdata[3:0];
				REG_DOWN_TASKS_PER_CORE: cfg_q.down_tasks_per_core <= cfg_wdata[3:0];
				REG_GPU_BOOST_LOAD:      cfg_q.gpu_boost_load      <= cfg_wdata[6:0];
				REG_BUSY_UP_PCT:         cfg_q.busy_up_pct         <= cfg_wdata[6:0];
				REG_LOWEST_LEVEL_LOCK:   cfg_q.lowest_level_lock   <= cfg_wdata[3:0];
				REG_HIGHEST_LEVEL_LOCK:  cfg_q.highest_level_lock  <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// input register: capture a sample on every accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
		end
	end

	hpg_step #(
		.NUM_CORES (NUM_CORES)
	) u_step (
		.cfg     (cfg_q),
		.item    (item_s1),
		.st      (st_q),
		.lvl     (lvl_q),
		.st_nxt  (st_nxt),
		.lvl_nxt (lvl_nxt),
		.res     (res_nxt)
	);

	// governor state advances once per tick, together with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			lvl_q <= '0;
		end else if (advance) begin
			st_q  <= st_nxt;
			lvl_q <= lvl_nxt;
		end
	end

	// result register: hold while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = OUT_TDATA_W'(res_s2);

	assign lvl_x = LVL_CALC_W'(lvl_q);

	a_level_cap: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_x <= MAX_LVL)
		else $error("hotplug level above the core-count cap");

	a_awake_limit: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.asleep_mode |-> lvl_x <= AWAKE_LEVEL_CAP)
		else $error("awake mode with level above the screen-on limit");

	a_asleep_floor: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.asleep_mode |-> lvl_x >= SLEEP_FLOOR)
		else $error("asleep mode with level below the suspend floor");

	a_change_clears: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(lvl_q) |-> (st_q.up_counter == '0 && st_q.down_counter == '0))
		else $error("level changed without clearing the hysteresis counters");

endmodule
